// ===== sv/rgbds_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RGBA8 gamma-correct 2x2 box downsampler.
// Holds the word types, the fixed-point width constants and the gamma table builder.
package rgbds_pkg;

  localparam int LINEAR_FRACTION_BITS_DEF = 8;
  localparam int LIN_INT_BITS             = 18;
  localparam int LIN_ENTRY_BITS           = 64;
  localparam int SEARCH_ROUNDS            = 40;

  typedef logic [255:0][LIN_ENTRY_BITS-1:0] lin_tab_t;

  typedef struct packed {
    logic [31:0] top_left_pixel;
    logic [31:0] top_right_pixel;
    logic [31:0] bottom_left_pixel;
    logic [31:0] bottom_right_pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  // floor(v^2.2 * 2^fbits): largest t with t^5 <= v^11 * 2^(5*fbits)
  function automatic logic [LIN_ENTRY_BITS-1:0] lin_entry(input int unsigned v,
                                                          input int unsigned fbits);
    logic [191:0]                target;
    logic [191:0]                pw;
    logic [LIN_ENTRY_BITS-1:0]   lo;
    logic [LIN_ENTRY_BITS-1:0]   hi;
    logic [LIN_ENTRY_BITS-1:0]   mid;
    logic [191:0]                vx;
    logic [191:0]                mx;
    target = 192'd1;
    vx     = 192'(v);
    for (int i = 0; i < 11; i++) begin
      target = target * vx;
    end
    target = target << (5 * fbits);
    lo = '0;
    hi = LIN_ENTRY_BITS'(1) << (LIN_INT_BITS + fbits);
    for (int r = 0; r < SEARCH_ROUNDS; r++) begin
      if (hi - lo > LIN_ENTRY_BITS'(1)) begin
        mid = lo + ((hi - lo) >> 1);
        mx  = 192'(mid);
        pw  = 192'd1;
        for (int i = 0; i < 5; i++) begin
          pw = pw * mx;
        end
        if (pw <= target) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo;
  endfunction

  function automatic lin_tab_t lin_table(input int unsigned fbits);
    lin_tab_t t;
    for (int v = 0; v < 256; v++) begin
      t[v] = lin_entry(v, fbits);
    end
    return t;
  endfunction

endpackage

// ===== sv/rgba8_gamma_box_downsample.sv =====
`timescale 1ns / 1ps
// Gamma-correct 2x2 box downsampler, RGBA8 quad in, RGBA8 pixel out.
// It has 10 register stages: linearize, sum, 8 search steps.
// Throughput: one quad per cycle; each stage stalls only when it holds a word
// that the next stage cannot take. Gamma tables are constants built at elaboration.
// Reset clears the stage valid bits only; no clearing pass.
module rgba8_gamma_box_downsample #(
  parameter int LINEAR_FRACTION_BITS = rgbds_pkg::LINEAR_FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 quad_valid,
  output logic                 quad_ready,
  input  rgbds_pkg::in_word_t  quad,
  output logic                 pixel_valid,
  input  logic                 pixel_ready,
  output rgbds_pkg::out_word_t pixel
);

  localparam int LW     = rgbds_pkg::LIN_INT_BITS + LINEAR_FRACTION_BITS;
  localparam int SW     = LW + 2;
  localparam int STEPS  = 8;
  localparam int STAGES = STEPS + 2;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  logic [LW-1:0] lin0 [4][3];
  logic [2:0]    cnt0;
  logic [7:0]    alpha0;

  logic [SW-1:0] sum_s   [STEPS+1][3];
  logic [7:0]    v_s     [STEPS+1][3];
  logic [2:0]    cnt_s   [STEPS+1];
  logic [7:0]    alpha_s [STEPS+1];

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || pixel_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= quad_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign quad_ready = en[0];

  rgbds_lin #(.LINEAR_FRACTION_BITS(LINEAR_FRACTION_BITS)) u_lin (
    .clk   (clk),
    .en    (en[0]),
    .quad  (quad),
    .lin   (lin0),
    .cnt   (cnt0),
    .alpha (alpha0)
  );

  rgbds_acc #(.LINEAR_FRACTION_BITS(LINEAR_FRACTION_BITS)) u_acc (
    .clk      (clk),
    .en       (en[1]),
    .lin      (lin0),
    .cnt_in   (cnt0),
    .alpha_in (alpha0),
    .sum      (sum_s[0]),
    .cnt      (cnt_s[0]),
    .alpha    (alpha_s[0])
  );

  assign v_s[0][0] = 8'd0;
  assign v_s[0][1] = 8'd0;
  assign v_s[0][2] = 8'd0;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    rgbds_inv #(
      .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS),
      .BIT                  (STEPS - 1 - i)
    ) u_inv (
      .clk      (clk),
      .en       (en[i+2]),
      .sum_in   (sum_s[i]),
      .v_in     (v_s[i]),
      .cnt_in   (cnt_s[i]),
      .alpha_in (alpha_s[i]),
      .sum      (sum_s[i+1]),
      .v        (v_s[i+1]),
      .cnt      (cnt_s[i+1]),
      .alpha    (alpha_s[i+1])
    );
  end

  // drop color when no pixel was included
  assign pixel_valid = vld[STAGES-1];
  assign pixel.red   = (cnt_s[STEPS] == 3'd0) ? 8'd0 : v_s[STEPS][0];
  assign pixel.green = (cnt_s[STEPS] == 3'd0) ? 8'd0 : v_s[STEPS][1];
  assign pixel.blue  = (cnt_s[STEPS] == 3'd0) ? 8'd0 : v_s[STEPS][2];
  assign pixel.alpha = alpha_s[STEPS];

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> cnt0 <= 3'd4)
    else $error("included pixel count above four");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && cnt_s[0] == 3'd0) |->
      (sum_s[0][0] == '0 && sum_s[0][1] == '0 && sum_s[0][2] == '0))
    else $error("nonzero color sum with no included pixel");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !en[5]) |=> (vld[5] && $stable(v_s[4][0]) && $stable(alpha_s[4])))
    else $error("stalled stage lost its word");

endmodule

// ===== sv/rgbds_lin.sv =====
`timescale 1ns / 1ps
// Linearize stage: maps each color byte through the gamma table, masks out
// transparent pixels, counts included pixels and averages alpha. Uses rgbds_pkg.
module rgbds_lin #(
  parameter int LINEAR_FRACTION_BITS = rgbds_pkg::LINEAR_FRACTION_BITS_DEF,
  localparam int LW = rgbds_pkg::LIN_INT_BITS + LINEAR_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  rgbds_pkg::in_word_t quad,
  output logic [LW-1:0]      lin [4][3],
  output logic [2:0]         cnt,
  output logic [7:0]         alpha
);

  localparam rgbds_pkg::lin_tab_t LIN = rgbds_pkg::lin_table(LINEAR_FRACTION_BITS);

  logic [31:0]   px [4];
  logic [3:0]    inc;
  logic [LW-1:0] lin_next [4][3];
  logic [2:0]    cnt_next;
  logic [9:0]    alpha_sum;

  assign px[0] = quad.top_left_pixel;
  assign px[1] = quad.top_right_pixel;
  assign px[2] = quad.bottom_left_pixel;
  assign px[3] = quad.bottom_right_pixel;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      inc[p] = (px[p][31:24] != 8'd0);
      for (int c = 0; c < 3; c++) begin
        lin_next[p][c] = inc[p] ? LIN[px[p][8*c +: 8]][LW-1:0] : '0;
      end
    end
    cnt_next  = 3'(inc[0]) + 3'(inc[1]) + 3'(inc[2]) + 3'(inc[3]);
    alpha_sum = 10'(px[0][31:24]) + 10'(px[1][31:24])
              + 10'(px[2][31:24]) + 10'(px[3][31:24]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin   <= lin_next;
      cnt   <= cnt_next;
      alpha <= alpha_sum[9:2];
    end
  end

endmodule

// ===== sv/rgbds_acc.sv =====
`timescale 1ns / 1ps
// Accumulate stage: sums the four linear values of each color channel.
// Uses rgbds_pkg for width constants.
module rgbds_acc #(
  parameter int LINEAR_FRACTION_BITS = rgbds_pkg::LINEAR_FRACTION_BITS_DEF,
  localparam int LW = rgbds_pkg::LIN_INT_BITS + LINEAR_FRACTION_BITS,
  localparam int SW = LW + 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [LW-1:0] lin [4][3],
  input  logic [2:0]    cnt_in,
  input  logic [7:0]    alpha_in,
  output logic [SW-1:0] sum [3],
  output logic [2:0]    cnt,
  output logic [7:0]    alpha
);

  logic [SW-1:0] sum_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = SW'(lin[0][c]) + SW'(lin[1][c]) + SW'(lin[2][c]) + SW'(lin[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= sum_next;
      cnt   <= cnt_in;
      alpha <= alpha_in;
    end
  end

endmodule

// ===== sv/rgbds_inv.sv =====
`timescale 1ns / 1ps
// Inverse gamma search step: decides one result bit per channel by testing
// count * LIN[trial] <= sum (count 0 taken as 1). Uses rgbds_pkg for the gamma table.
module rgbds_inv #(
  parameter int LINEAR_FRACTION_BITS = rgbds_pkg::LINEAR_FRACTION_BITS_DEF,
  parameter int BIT = 7,
  localparam int LW = rgbds_pkg::LIN_INT_BITS + LINEAR_FRACTION_BITS,
  localparam int SW = LW + 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] sum_in [3],
  input  logic [7:0]    v_in [3],
  input  logic [2:0]    cnt_in,
  input  logic [7:0]    alpha_in,
  output logic [SW-1:0] sum [3],
  output logic [7:0]    v [3],
  output logic [2:0]    cnt,
  output logic [7:0]    alpha
);

  localparam rgbds_pkg::lin_tab_t LIN = rgbds_pkg::lin_table(LINEAR_FRACTION_BITS);
  localparam logic [7:0] TRY_BIT = 8'(1 << BIT);

  logic [7:0]    trial  [3];
  logic [LW-1:0] ent    [3];
  logic [SW-1:0] scaled [3];
  logic [7:0]    v_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = v_in[c] | TRY_BIT;
      ent[c]   = LIN[trial[c]][LW-1:0];
      case (cnt_in)
        3'd2:    scaled[c] = {1'b0, ent[c], 1'b0};
        3'd3:    scaled[c] = {2'b00, ent[c]} + {1'b0, ent[c], 1'b0};
        3'd4:    scaled[c] = {ent[c], 2'b00};
        default: scaled[c] = {2'b00, ent[c]};
      endcase
      v_next[c] = (scaled[c] <= sum_in[c]) ? trial[c] : v_in[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= sum_in;
      v     <= v_next;
      cnt   <= cnt_in;
      alpha <= alpha_in;
    end
  end

endmodule

// ===== test/tb_rgba8_gamma_box_downsample.sv =====
`timescale 1ns / 1ps
// Testbench for rgba8_gamma_box_downsample: streams 2x2 RGBA8 quads with random idling on
// both sides and checks each pixel against set values or a local gamma-table predictor.
// Depends on rgbds_pkg for the word types and the fixed-point width constants.
module tb_rgba8_gamma_box_downsample;

  localparam int FRAC        = rgbds_pkg::LINEAR_FRACTION_BITS_DEF;
  localparam int LUT_TOP_BIT = rgbds_pkg::LIN_INT_BITS + FRAC - 1;
  localparam int N_RANDOM    = 2000;
  localparam int N_CALM      = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                 known;
    rgbds_pkg::in_word_t  q;
    rgbds_pkg::out_word_t want;
  } quad_row_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 quad_valid  = 1'b0;
  logic                 quad_ready;
  rgbds_pkg::in_word_t  quad        = '0;
  logic                 pixel_valid;
  logic                 pixel_ready = 1'b0;
  rgbds_pkg::out_word_t pixel;

  logic [63:0]          lin_lut [256];
  rgbds_pkg::out_word_t expected_pixels [$];
  int                   mismatches = 0;
  int                   stall_left = 0;
  int                   cycles     = 0;
  bit                   calm       = 1'b0;

  quad_row_t quad_rows [15] = '{
    '{1'b1, '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
            '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
            '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
    '{1'b1, '{32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF},
            '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{1'b1, '{32'h80402010, 32'h80402010, 32'h80402010, 32'h80402010},
            '{8'h10, 8'h20, 8'h40, 8'h80}},
    '{1'b1, '{32'h01ABCDEF, 32'h00123456, 32'h00123456, 32'h00123456},
            '{8'hEF, 8'hCD, 8'hAB, 8'h00}},
    '{1'b1, '{32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'hFF010203},
            '{8'h03, 8'h02, 8'h01, 8'h3F}},
    '{1'b1, '{32'hFEFEFEFE, 32'hFEFEFEFE, 32'hFEFEFEFE, 32'hFEFEFEFE},
            '{8'hFE, 8'hFE, 8'hFE, 8'hFE}},
    '{1'b1, '{32'hFF555555, 32'hFF555555, 32'hFF555555, 32'hFE555555},
            '{8'h55, 8'h55, 8'h55, 8'hFE}},
    '{1'b0, '{32'hFF000000, 32'hFFFFFFFF, 32'hFF000000, 32'hFFFFFFFF}, '0},
    '{1'b0, '{32'hFFFFFFFF, 32'hFF000000, 32'hFF000000, 32'h00FFFFFF}, '0},
    '{1'b0, '{32'h01A5C3E7, 32'h01123456, 32'h01FEDCBA, 32'h01789ABC}, '0},
    '{1'b0, '{32'h030F0F0F, 32'h03F0F0F0, 32'h03AA55AA, 32'h0355AA55}, '0},
    '{1'b0, '{32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000, 32'hFF7F7F7F}, '0},
    '{1'b0, '{32'h80FF00FF, 32'h40000000, 32'h00FFFFFF, 32'h00000000}, '0},
    '{1'b0, '{32'hFF010101, 32'hFF000000, 32'hFF020202, 32'hFF030303}, '0}
  };

  rgba8_gamma_box_downsample uut (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .quad       (quad),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel)
  );

  always #2 clk = ~clk;

  function automatic rgbds_pkg::out_word_t downsample(input rgbds_pkg::in_word_t q);
    logic [31:0]          px [4];
    logic [63:0]          acc [3];
    logic [7:0]           chan [3];
    logic [9:0]           asum;
    int                   n;
    int                   v;
    rgbds_pkg::out_word_t r;
    px[0] = q.top_left_pixel;
    px[1] = q.top_right_pixel;
    px[2] = q.bottom_left_pixel;
    px[3] = q.bottom_right_pixel;
    acc   = '{default: '0};
    asum  = '0;
    n     = 0;
    for (int p = 0; p < 4; p++) begin
      asum += 10'(px[p][31:24]);
      if (px[p][31:24] != 8'd0) begin
        n++;
        for (int c = 0; c < 3; c++) begin
          acc[c] += lin_lut[px[p][8*c +: 8]];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      chan[c] = 8'd0;
      if (n != 0) begin
        v = 255;
        while (v > 0 && lin_lut[v] > acc[c] / 64'(n)) v--;
        chan[c] = 8'(v);
      end
    end
    r.red   = chan[0];
    r.green = chan[1];
    r.blue  = chan[2];
    r.alpha = asum[9:2];
    return r;
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [7:0] b [4];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0:       b[i] = 8'h00;
        1:       b[i] = 8'hFF;
        default: b[i] = 8'($urandom());
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2: b[3] = 8'h00;
      3:       b[3] = 8'hFF;
      4:       b[3] = 8'($urandom_range(1, 3));
      default: b[3] = 8'($urandom());
    endcase
    return {b[3], b[2], b[1], b[0]};
  endfunction

  task automatic send(input rgbds_pkg::in_word_t w, input bit known,
                      input rgbds_pkg::out_word_t want);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      quad_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quad_valid <= 1'b1;
    quad       <= w;
    do @(posedge clk); while (!quad_ready);
    expected_pixels.insert(expected_pixels.size(), known ? want : downsample(w));
  endtask

  always @(posedge clk) begin
    rgbds_pkg::out_word_t want;
    if (!rst && pixel_valid && pixel_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel word %h", pixel);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel.red !== want.red) begin
          $error("red: expected %0h, got %0h", want.red, pixel.red);
          mismatches++;
        end
        if (pixel.green !== want.green) begin
          $error("green: expected %0h, got %0h", want.green, pixel.green);
          mismatches++;
        end
        if (pixel.blue !== want.blue) begin
          $error("blue: expected %0h, got %0h", want.blue, pixel.blue);
          mismatches++;
        end
        if (pixel.alpha !== want.alpha) begin
          $error("alpha: expected %0h, got %0h", want.alpha, pixel.alpha);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      pixel_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 9);
      pixel_ready <= 1'b0;
    end else begin
      pixel_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [191:0]        goal;
    logic [191:0]        pw;
    logic [191:0]        t;
    logic [191:0]        cand;
    rgbds_pkg::in_word_t w;
    logic [31:0]         px;
    // floor(v^2.2 * 2^FRAC): largest t with t^5 <= v^11 * 2^(5*FRAC), built bit by bit
    for (int v = 0; v < 256; v++) begin
      goal = 192'd1;
      for (int i = 0; i < 11; i++) goal = goal * 192'(v);
      goal = goal << (5 * FRAC);
      t = '0;
      for (int b = LUT_TOP_BIT; b >= 0; b--) begin
        cand = t | (192'd1 << b);
        pw   = 192'd1;
        for (int i = 0; i < 5; i++) pw = pw * cand;
        if (pw <= goal) t = cand;
      end
      lin_lut[v] = t[63:0];
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (quad_rows[i]) begin
      send(quad_rows[i].q, quad_rows[i].known, quad_rows[i].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= N_RANDOM - N_CALM);
      case ($urandom_range(0, 19))
        0: begin
          w.top_left_pixel     = {8'h00, 24'($urandom())};
          w.top_right_pixel    = {8'h00, 24'($urandom())};
          w.bottom_left_pixel  = {8'h00, 24'($urandom())};
          w.bottom_right_pixel = {8'h00, 24'($urandom())};
        end
        1: begin
          px = rand_pixel();
          w  = {px, px, px, px};
        end
        default: begin
          w.top_left_pixel     = rand_pixel();
          w.top_right_pixel    = rand_pixel();
          w.bottom_left_pixel  = rand_pixel();
          w.bottom_right_pixel = rand_pixel();
        end
      endcase
      send(w, 1'b0, '0);
    end
    quad_valid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== rgba8_gamma_box_downsample.f =====
sv/rgbds_pkg.sv
sv/rgbds_lin.sv
sv/rgbds_acc.sv
sv/rgbds_inv.sv
sv/rgba8_gamma_box_downsample.sv
test/tb_rgba8_gamma_box_downsample.sv
